### hdl/plt_pkg.sv
// ============================================================================
// plt_pkg
// Shared types and constants for the particle linear transport pipeline.
// ============================================================================
`default_nettype none

package plt_pkg;

   localparam int COORD_W   = 32;
   localparam int COEF_W    = 20;
   localparam int ROW_W     = 3 * COEF_W;
   localparam int INV_W     = 32;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = ROW_W;

   // register indexes of the configuration port
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_X_ROW_POSITION    = 3'd0,
      CSR_X_ROW_ANGLE       = 3'd1,
      CSR_Y_ROW_POSITION    = 3'd2,
      CSR_Y_ROW_ANGLE       = 3'd3,
      CSR_INV_APERTURE_X_SQ = 3'd4,
      CSR_INV_APERTURE_Y_SQ = 3'd5
   } csr_index_type;

   // the four transverse coordinates of one particle
   typedef struct packed {
      logic signed [COORD_W-1:0] pos_x;
      logic signed [COORD_W-1:0] angle_x;
      logic signed [COORD_W-1:0] pos_y;
      logic signed [COORD_W-1:0] angle_y;
   } coord_set_type;

   // load enables of the two transform stages
   typedef struct packed {
      logic load_prod;
      logic load_coord;
   } xform_ctrl_type;

   // load enables of the four aperture stages
   typedef struct packed {
      logic load_square;
      logic load_partial;
      logic load_total;
      logic load_result;
   } aper_ctrl_type;

endpackage

`default_nettype wire

### hdl/plt_transform.sv
// ============================================================================
// plt_transform
// Two stages: coefficient products, then sum, round half up and saturate.
// ============================================================================
`default_nettype none

module plt_transform import plt_pkg::*; (
   input  logic                      clock,
   input  xform_ctrl_type            ctrl,
   input  coord_set_type             coord_in,
   input  logic signed [COORD_W-1:0] momentum_dev,
   input  logic                      alive_in,
   input  logic [ROW_W-1:0]          row_x_pos,
   input  logic [ROW_W-1:0]          row_x_ang,
   input  logic [ROW_W-1:0]          row_y_pos,
   input  logic [ROW_W-1:0]          row_y_ang,
   output coord_set_type             coord_out,
   output logic                      alive_out
);

   localparam int PROD_W  = COEF_W + COORD_W;
   localparam int SUM_W   = PROD_W + 3;
   localparam int SHIFT   = 14;
   localparam int RND_W   = SUM_W - SHIFT;
   localparam logic signed [SUM_W-1:0] ROUND_BIAS = SUM_W'(1 << (SHIFT - 1));
   localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
   localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

   logic signed [PROD_W-1:0] prod_in [4][3];
   logic signed [PROD_W-1:0] prod_ff [4][3];
   coord_set_type            orig_ff;
   logic                     alive1_ff;
   coord_set_type            coord_in_s2;
   coord_set_type            coord_ff;
   logic                     alive2_ff;

   function automatic logic signed [COEF_W-1:0] coef_of(input logic [ROW_W-1:0] row,
                                                        input int k);
      coef_of = signed'(row[k*COEF_W +: COEF_W]);
   endfunction

   function automatic logic signed [COORD_W-1:0] round_sat(
      input logic signed [PROD_W-1:0] a,
      input logic signed [PROD_W-1:0] b,
      input logic signed [PROD_W-1:0] c);
      logic signed [SUM_W-1:0] s;
      logic signed [RND_W-1:0] r;
      s = SUM_W'(a) + SUM_W'(b) + SUM_W'(c) + ROUND_BIAS;
      r = s[SUM_W-1:SHIFT];
      // saturate when the bits above the sign of Q1.30 disagree
      if (r[RND_W-1:COORD_W-1] != {(RND_W-COORD_W+1){r[RND_W-1]}}) begin
         round_sat = r[RND_W-1] ? COORD_MIN : COORD_MAX;
      end else begin
         round_sat = r[COORD_W-1:0];
      end
   endfunction

   always_comb begin
      prod_in[0][0] = coef_of(row_x_pos, 0) * coord_in.pos_x;
      prod_in[0][1] = coef_of(row_x_pos, 1) * coord_in.angle_x;
      prod_in[0][2] = coef_of(row_x_pos, 2) * momentum_dev;
      prod_in[1][0] = coef_of(row_x_ang, 0) * coord_in.pos_x;
      prod_in[1][1] = coef_of(row_x_ang, 1) * coord_in.angle_x;
      prod_in[1][2] = coef_of(row_x_ang, 2) * momentum_dev;
      prod_in[2][0] = coef_of(row_y_pos, 0) * coord_in.pos_y;
      prod_in[2][1] = coef_of(row_y_pos, 1) * coord_in.angle_y;
      prod_in[2][2] = coef_of(row_y_pos, 2) * momentum_dev;
      prod_in[3][0] = coef_of(row_y_ang, 0) * coord_in.pos_y;
      prod_in[3][1] = coef_of(row_y_ang, 1) * coord_in.angle_y;
      prod_in[3][2] = coef_of(row_y_ang, 2) * momentum_dev;
   end

   always_ff @(posedge clock) begin
      if (ctrl.load_prod) begin
         for (int r = 0; r < 4; r++) begin
            for (int k = 0; k < 3; k++) begin
               prod_ff[r][k] <= prod_in[r][k];
            end
         end
         orig_ff   <= coord_in;
         alive1_ff <= alive_in;
      end
   end

   // dead particles keep their coordinates
   always_comb begin
      if (alive1_ff) begin
         coord_in_s2.pos_x   = round_sat(prod_ff[0][0], prod_ff[0][1], prod_ff[0][2]);
         coord_in_s2.angle_x = round_sat(prod_ff[1][0], prod_ff[1][1], prod_ff[1][2]);
         coord_in_s2.pos_y   = round_sat(prod_ff[2][0], prod_ff[2][1], prod_ff[2][2]);
         coord_in_s2.angle_y = round_sat(prod_ff[3][0], prod_ff[3][1], prod_ff[3][2]);
      end else begin
         coord_in_s2 = orig_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load_coord) begin
         coord_ff  <= coord_in_s2;
         alive2_ff <= alive1_ff;
      end
   end

   assign coord_out = coord_ff;
   assign alive_out = alive2_ff;

endmodule

`default_nettype wire

### hdl/plt_aperture.sv
// ============================================================================
// plt_aperture
// Four stages: squares, partial products, plane totals, ellipse test.
// ============================================================================
`default_nettype none

module plt_aperture import plt_pkg::*; (
   input  logic             clock,
   input  aper_ctrl_type    ctrl,
   input  coord_set_type    coord_in,
   input  logic             alive_in,
   input  logic [INV_W-1:0] inv_x,
   input  logic [INV_W-1:0] inv_y,
   output coord_set_type    coord_out,
   output logic             alive_out
);

   localparam int SQ_W  = 2 * COORD_W - 1;
   localparam int LO_W  = 32;
   localparam int PLO_W = LO_W + INV_W;
   localparam int PHI_W = SQ_W - LO_W + INV_W;
   localparam int TOT_W = PHI_W + LO_W;
   localparam int SUM_W = TOT_W + 1;
   // 1.0 in the Q1.30 squared times Q16.16 scale is 2^76
   localparam logic [SUM_W-1:0] APER_LIMIT = SUM_W'(1) << 76;

   logic [COORD_W-1:0] mag_x;
   logic [COORD_W-1:0] mag_y;
   logic [SQ_W-1:0]    sq_x_ff;
   logic [SQ_W-1:0]    sq_y_ff;
   coord_set_type      coord3_ff;
   logic               alive3_ff;
   logic [PLO_W-1:0]   plo_x_ff;
   logic [PLO_W-1:0]   plo_y_ff;
   logic [PHI_W-1:0]   phi_x_ff;
   logic [PHI_W-1:0]   phi_y_ff;
   coord_set_type      coord4_ff;
   logic               alive4_ff;
   logic [TOT_W-1:0]   tot_x_ff;
   logic [TOT_W-1:0]   tot_y_ff;
   coord_set_type      coord5_ff;
   logic               alive5_ff;
   logic [SUM_W-1:0]   sum;
   coord_set_type      coord6_ff;
   logic               alive6_ff;

   // magnitude of the most negative value is 2^31, still fits unsigned
   assign mag_x = coord_in.pos_x[COORD_W-1] ? COORD_W'(-coord_in.pos_x) : coord_in.pos_x;
   assign mag_y = coord_in.pos_y[COORD_W-1] ? COORD_W'(-coord_in.pos_y) : coord_in.pos_y;

   // operands widened so the full product is kept
   always_ff @(posedge clock) begin
      if (ctrl.load_square) begin
         sq_x_ff   <= SQ_W'(mag_x) * SQ_W'(mag_x);
         sq_y_ff   <= SQ_W'(mag_y) * SQ_W'(mag_y);
         coord3_ff <= coord_in;
         alive3_ff <= alive_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load_partial) begin
         plo_x_ff  <= PLO_W'(sq_x_ff[LO_W-1:0]) * PLO_W'(inv_x);
         plo_y_ff  <= PLO_W'(sq_y_ff[LO_W-1:0]) * PLO_W'(inv_y);
         phi_x_ff  <= PHI_W'(sq_x_ff[SQ_W-1:LO_W]) * PHI_W'(inv_x);
         phi_y_ff  <= PHI_W'(sq_y_ff[SQ_W-1:LO_W]) * PHI_W'(inv_y);
         coord4_ff <= coord3_ff;
         alive4_ff <= alive3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load_total) begin
         tot_x_ff  <= {phi_x_ff, {LO_W{1'b0}}} + TOT_W'(plo_x_ff);
         tot_y_ff  <= {phi_y_ff, {LO_W{1'b0}}} + TOT_W'(plo_y_ff);
         coord5_ff <= coord4_ff;
         alive5_ff <= alive4_ff;
      end
   end

   assign sum = SUM_W'(tot_x_ff) + SUM_W'(tot_y_ff);

   always_ff @(posedge clock) begin
      if (ctrl.load_result) begin
         coord6_ff <= coord5_ff;
         alive6_ff <= alive5_ff && (sum <= APER_LIMIT);
      end
   end

   assign coord_out = coord6_ff;
   assign alive_out = alive6_ff;

endmodule

`default_nettype wire

### hdl/particle_linear_transport.sv
// ============================================================================
// particle_linear_transport
// First-order transfer matrix step with elliptical aperture loss test.
// ============================================================================
// a req transaction reaches rsp_tvalid through the six register stages,
// the first of which loads at the edge that accepts it
// throughput: one particle per cycle while rsp_tready is high, every stage loads while its successor moves on
// a stage holds only while the one after it is full and stalled, so bubbles are
// squeezed out
// reset (synchronous, active high) empties the pipeline and clears all
// configuration registers to zero
`default_nettype none

module particle_linear_transport import plt_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   // configuration write port
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   // particle in
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [159:0]          req_tdata,   // pos_x, angle_x, pos_y, angle_y, momentum_dev
   input  logic [0:0]            req_tuser,   // alive_in
   // particle out
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [127:0]          rsp_tdata,   // new_pos_x, new_angle_x, new_pos_y, new_angle_y
   output logic [0:0]            rsp_tuser    // alive_out
);

   localparam int PIPE_DEPTH = 6;

   // configuration registers
   logic [ROW_W-1:0] x_row_pos_ff;
   logic [ROW_W-1:0] x_row_ang_ff;
   logic [ROW_W-1:0] y_row_pos_ff;
   logic [ROW_W-1:0] y_row_ang_ff;
   logic [INV_W-1:0] inv_x_ff;
   logic [INV_W-1:0] inv_y_ff;

   // pipeline occupancy, one bit per stage
   logic [PIPE_DEPTH-1:0] valid_ff;
   logic [PIPE_DEPTH-1:0] valid_in;
   logic [PIPE_DEPTH-1:0] load;

   coord_set_type  req_coord;
   coord_set_type  xf_coord;
   logic           xf_alive;
   coord_set_type  rsp_coord;
   logic           rsp_alive;
   xform_ctrl_type xf_ctrl;
   aper_ctrl_type  ap_ctrl;

   // csr writes, unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         x_row_pos_ff <= '0;
         x_row_ang_ff <= '0;
         y_row_pos_ff <= '0;
         y_row_ang_ff <= '0;
         inv_x_ff     <= '0;
         inv_y_ff     <= '0;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_X_ROW_POSITION:    x_row_pos_ff <= csr_wdata;
            CSR_X_ROW_ANGLE:       x_row_ang_ff <= csr_wdata;
            CSR_Y_ROW_POSITION:    y_row_pos_ff <= csr_wdata;
            CSR_Y_ROW_ANGLE:       y_row_ang_ff <= csr_wdata;
            CSR_INV_APERTURE_X_SQ: inv_x_ff     <= csr_wdata[INV_W-1:0];
            CSR_INV_APERTURE_Y_SQ: inv_y_ff     <= csr_wdata[INV_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // a stage loads when it is empty or the stage after it moves on;
   // the last stage moves on when the rsp transaction completes
   always_comb begin
      load[PIPE_DEPTH-1] = !valid_ff[PIPE_DEPTH-1] || rsp_tready;
      for (int k = PIPE_DEPTH - 2; k >= 0; k--) begin
         load[k] = !valid_ff[k] || load[k+1];
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (load[0]) begin
         valid_in[0] = req_tvalid;
      end
      for (int k = 1; k < PIPE_DEPTH; k++) begin
         if (load[k]) begin
            valid_in[k] = valid_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_tready = load[0];

   // unpack the request, first field in the lowest bits
   always_comb begin
      req_coord.pos_x   = req_tdata[31:0];
      req_coord.angle_x = req_tdata[63:32];
      req_coord.pos_y   = req_tdata[95:64];
      req_coord.angle_y = req_tdata[127:96];
   end

   assign xf_ctrl.load_prod  = load[0];
   assign xf_ctrl.load_coord = load[1];

   plt_transform u_transform (
      .clock        (clock),
      .ctrl         (xf_ctrl),
      .coord_in     (req_coord),
      .momentum_dev (req_tdata[159:128]),
      .alive_in     (req_tuser[0]),
      .row_x_pos    (x_row_pos_ff),
      .row_x_ang    (x_row_ang_ff),
      .row_y_pos    (y_row_pos_ff),
      .row_y_ang    (y_row_ang_ff),
      .coord_out    (xf_coord),
      .alive_out    (xf_alive)
   );

   assign ap_ctrl.load_square  = load[2];
   assign ap_ctrl.load_partial = load[3];
   assign ap_ctrl.load_total   = load[4];
   assign ap_ctrl.load_result  = load[5];

   plt_aperture u_aperture (
      .clock     (clock),
      .ctrl      (ap_ctrl),
      .coord_in  (xf_coord),
      .alive_in  (xf_alive),
      .inv_x     (inv_x_ff),
      .inv_y     (inv_y_ff),
      .coord_out (rsp_coord),
      .alive_out (rsp_alive)
   );

   // the last stage register is the output register
   assign rsp_tvalid   = valid_ff[PIPE_DEPTH-1];
   assign rsp_tdata    = {rsp_coord.angle_y, rsp_coord.pos_y,
                          rsp_coord.angle_x, rsp_coord.pos_x};
   assign rsp_tuser[0] = rsp_alive;

   // reset empties every stage
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (valid_ff == '0) && !rsp_tvalid)
      else $error("pipeline not empty after reset");

   // back pressure reaches the input only when every stage is full
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (&valid_ff))
      else $error("input stalled with an empty stage");

   // an accepted transaction always occupies the first stage
   a_accept_loads: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> valid_ff[0])
      else $error("accepted transaction lost at first stage");

endmodule

`default_nettype wire
